// ----- rtl/dfd_pkg.sv -----
// dfd_pkg: types and constants shared by the discrete frechet distance unit
// no dependencies
`timescale 1ns / 1ps

package dfd_pkg;

	localparam int MAX_POINTS = 64;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int DIST_W     = SQ_W + 1;

	localparam logic       OP_LOAD    = 1'b0;
	localparam logic       OP_QUERY   = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_REF  = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	typedef struct packed {
		logic                      opcode;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last;
	} dfd_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_squared;
		logic [1:0]        status;
		logic              done_res;
	} dfd_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} coord_t;

	// dp wavefront token passed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] diag;
	} dp_tok_t;

endpackage

// ----- rtl/discrete_frechet_distance_unit.sv -----
// discrete_frechet_distance_unit: top level, control and the row of dp cells
// depends on dfd_pkg and dfd_cell
`timescale 1ns / 1ps

// Usage: a beat is taken at a rising edge where start is high and busy is low.
// opcode load stores a reference point in the next free cell (up to MAX_POINTS,
// further points set the truncated status). opcode query sends a point into the
// cell row; a query beat can follow every cycle while busy is low. Each point
// walks the row one cell per cycle, the coordinates one register ahead of the
// dp values, so cell j squares its distance in the cycle before it merges left,
// up and diagonal values. A query beat with last set raises busy until its
// result leaves the end of the row: the strobe comes once that beat's token has
// passed the injection registers and every cell, and the next beat is taken no
// earlier than the cycle after the strobe. With no reference stored, a last
// query beat gives dist_squared 0, status no-reference, in the next cycle;
// other query beats are then dropped. Every result is on result for exactly the
// one cycle strobe is high; the receiver cannot stall. Reset clears counters and
// flags; the point and row stores are not cleared and read only after a write.

module discrete_frechet_distance_unit import dfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dfd_in_t  item,
	output logic     strobe,
	output dfd_out_t result
);

	logic [CNT_W-1:0] count_q;
	logic             complete_q;
	logic             overflow_q;
	logic             first_q;
	logic             pending_q;
	logic             zero_q;
	logic [1:0]       status_q;
	coord_t           inj_coord_q;
	dp_tok_t          inj_tok_s1;
	dp_tok_t          inj_tok_s2;

	logic             accept;
	logic             load_acc;
	logic             query_acc;
	logic [CNT_W-1:0] eff_cnt;
	logic             has_room;
	logic             tail_done;
	coord_t           wr_pt;

	logic [MAX_POINTS-1:0] wr_vec;
	logic [MAX_POINTS-1:0] act_vec;
	coord_t                coord_c [MAX_POINTS+1];
	dp_tok_t               tok_c   [MAX_POINTS+1];

	assign accept    = start && !busy;
	assign load_acc  = accept && (item.opcode == OP_LOAD);
	assign query_acc = accept && (item.opcode == OP_QUERY);
	// a load after a closed reference starts over at cell zero
	assign eff_cnt   = complete_q ? '0 : count_q;
	assign has_room  = eff_cnt < CNT_W'(MAX_POINTS);
	assign wr_pt     = '{x: item.point_x, y: item.point_y};
	assign tail_done = tok_c[MAX_POINTS].valid && tok_c[MAX_POINTS].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			complete_q <= 1'b0;
			overflow_q <= 1'b0;
			first_q    <= 1'b1;
			pending_q  <= 1'b0;
			zero_q     <= 1'b0;
			status_q   <= ST_OK;
			inj_tok_s1 <= '0;
			inj_tok_s2 <= '0;
		end else begin
			zero_q     <= 1'b0;
			inj_tok_s1 <= '0;
			inj_tok_s2 <= inj_tok_s1;
			if (tail_done) begin
				pending_q <= 1'b0;
			end
			if (load_acc) begin
				first_q    <= 1'b1;
				complete_q <= item.last;
				if (has_room) begin
					count_q    <= eff_cnt + CNT_W'(1);
					overflow_q <= complete_q ? 1'b0 : overflow_q;
				end else begin
					count_q    <= eff_cnt;
					overflow_q <= 1'b1;
				end
			end else if (query_acc) begin
				if (count_q == '0) begin
					if (item.last) begin
						zero_q  <= 1'b1;
						first_q <= 1'b1;
					end
				end else begin
					first_q          <= item.last;
					inj_tok_s1.valid <= 1'b1;
					inj_tok_s1.first <= first_q;
					inj_tok_s1.last  <= item.last;
					inj_tok_s1.left  <= first_q ? '0 : '1;
					inj_tok_s1.diag  <= '1;
					if (item.last) begin
						pending_q <= 1'b1;
						status_q  <= overflow_q ? ST_TRUNC : ST_OK;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			inj_coord_q <= wr_pt;
		end
	end

	assign coord_c[0] = inj_coord_q;
	assign tok_c[0]   = inj_tok_s2;

	for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
		assign wr_vec[j]  = load_acc && has_room && (eff_cnt == CNT_W'(j));
		assign act_vec[j] = CNT_W'(j) < count_q;

		dfd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.coord_in  (coord_c[j]),
			.tok_in    (tok_c[j]),
			.active    (act_vec[j]),
			.wr_en     (wr_vec[j]),
			.wr_pt     (wr_pt),
			.coord_out (coord_c[j+1]),
			.tok_out   (tok_c[j+1])
		);
	end

	assign busy   = pending_q || zero_q;
	assign strobe = tail_done || zero_q;

	always_comb begin
		result.dist_squared = zero_q ? '0 : tok_c[MAX_POINTS].left;
		result.status       = zero_q ? ST_NO_REF : status_q;
		result.done_res     = 1'b1;
	end

endmodule

// ----- rtl/dfd_cell.sv -----
// dfd_cell: one systolic cell, holds one reference point and one dp row entry
// depends on dfd_pkg
`timescale 1ns / 1ps

module dfd_cell import dfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  coord_t  coord_in,
	input  dp_tok_t tok_in,
	input  logic    active,
	input  logic    wr_en,
	input  coord_t  wr_pt,
	output coord_t  coord_out,
	output dp_tok_t tok_out
);

	coord_t            ref_q;
	coord_t            coord_q;
	logic [DIST_W-1:0] prev_q;
	logic [SQ_W-1:0]   sqx_s1;
	logic [SQ_W-1:0]   sqy_s1;
	logic              tok_vld_q;
	dp_tok_t           tok_pl_q;

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic [COORD_W:0]        ax;
	logic [COORD_W:0]        ay;
	logic [DIST_W-1:0]       d;
	logic [DIST_W-1:0]       min_ul;
	logic [DIST_W-1:0]       min3;
	logic [DIST_W-1:0]       lo;
	logic [DIST_W-1:0]       cell_v;

	always_comb begin
		dx = {coord_in.x[COORD_W-1], coord_in.x} - {ref_q.x[COORD_W-1], ref_q.x};
		dy = {coord_in.y[COORD_W-1], coord_in.y} - {ref_q.y[COORD_W-1], ref_q.y};
		ax = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
		ay = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ref_q <= wr_pt;
		end
		coord_q <= coord_in;
		sqx_s1  <= ax[COORD_W-1:0] * ax[COORD_W-1:0];
		sqy_s1  <= ay[COORD_W-1:0] * ay[COORD_W-1:0];
	end

	always_comb begin
		d      = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		min_ul = (prev_q < tok_in.left) ? prev_q : tok_in.left;
		min3   = (min_ul < tok_in.diag) ? min_ul : tok_in.diag;
		// first query row only looks left
		lo     = tok_in.first ? tok_in.left : min3;
		cell_v = (lo > d) ? lo : d;
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid && active) begin
			prev_q <= cell_v;
		end
		tok_pl_q.first <= tok_in.first;
		tok_pl_q.last  <= tok_in.last;
		tok_pl_q.valid <= 1'b0;
		// inactive cells pass the corner value on untouched
		tok_pl_q.left  <= active ? cell_v : tok_in.left;
		tok_pl_q.diag  <= active ? prev_q : tok_in.diag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.valid;
		end
	end

	assign coord_out = coord_q;

	always_comb begin
		tok_out       = tok_pl_q;
		tok_out.valid = tok_vld_q;
	end

endmodule

// ----- rtl/dfd_checker.sv -----
// dfd_checker: port-level assertions for discrete_frechet_distance_unit
// depends on dfd_pkg; bound to the top level below
`timescale 1ns / 1ps

module dfd_checker import dfd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input dfd_in_t  item,
	input logic     strobe,
	input dfd_out_t result
);

	// results never come in adjacent cycles
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobes in back-to-back cycles");

	// no beat is taken in the cycle a result goes out
	a_busy_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("busy low while a result is shown");

	// a closing query beat raises busy, blocking input until its result
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.opcode == OP_QUERY) && item.last) |=> busy)
		else $error("busy not raised after the final query beat");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.status == ST_OK) || (result.status == ST_NO_REF)
			|| (result.status == ST_TRUNC)) && result.done_res)
		else $error("bad status or done_res on result");

endmodule

bind discrete_frechet_distance_unit dfd_checker u_dfd_checker (.*);

// ----- verif/tb_discrete_frechet_distance_unit.sv -----
// tb_discrete_frechet_distance_unit: self-checking testbench for the discrete frechet distance unit
// drives reference and query curves, tracks the dp row on its own and checks every result
// depends on dfd_pkg and discrete_frechet_distance_unit
`timescale 1ns / 1ps

module tb_discrete_frechet_distance_unit;
	import dfd_pkg::*;

	localparam int ITEM_TARGET  = 1000;
	localparam int QUIET_LIMIT  = 20 * (MAX_POINTS + 4);
	localparam int DRAIN_CYCLES = MAX_POINTS + 8;
	localparam int IDLE_PCT     = 28;
	localparam int CALM_FIRST   = 400;
	localparam int CALM_LAST    = 550;

	localparam int SPREAD_FULL  = 0;
	localparam int SPREAD_NEAR  = 1;
	localparam int SPREAD_EDGE  = 2;

	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	dfd_in_t  item_bus = '0;
	logic     strobe;
	dfd_out_t result;

	discrete_frechet_distance_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item_bus),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// own copy of the reference curve and the dp row
	logic signed [COORD_W-1:0] ref_xs [MAX_POINTS];
	logic signed [COORD_W-1:0] ref_ys [MAX_POINTS];
	logic [DIST_W-1:0]         dp_row [MAX_POINTS];
	int                        ref_len = 0;
	bit                        ref_closed = 1'b0;
	bit                        new_row = 1'b1;
	bit                        ref_overflow = 1'b0;

	dfd_in_t  point_queue [$];
	dfd_out_t dist_due [$];

	bit took_beat = 1'b0;
	int beats_sent = 0;
	int mismatches = 0;
	int load_beats = 0;
	int query_beats = 0;
	int results_seen = 0;
	int trunc_seen = 0;
	int noref_seen = 0;
	int quiet = 0;

	function automatic logic [DIST_W-1:0] sq_dist(logic signed [COORD_W-1:0] ax,
			logic signed [COORD_W-1:0] ay, logic signed [COORD_W-1:0] bx,
			logic signed [COORD_W-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return DIST_W'(dx * dx + dy * dy);
	endfunction

	function automatic logic [DIST_W-1:0] max33(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [DIST_W-1:0] min33(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// advance the frechet state by one accepted beat, queue the result if one is due
	task automatic frechet_step(input dfd_in_t b);
		logic [DIST_W-1:0] d;
		logic [DIST_W-1:0] up;
		logic [DIST_W-1:0] diag;
		logic [DIST_W-1:0] entry;
		dfd_out_t r;
		r = '0;
		r.done_res = 1'b1;
		if (b.opcode == OP_LOAD) begin
			load_beats++;
			if (ref_closed) begin
				ref_len = 0;
				ref_overflow = 1'b0;
				ref_closed = 1'b0;
			end
			new_row = 1'b1;
			if (ref_len < MAX_POINTS) begin
				ref_xs[ref_len] = b.point_x;
				ref_ys[ref_len] = b.point_y;
				ref_len++;
			end else begin
				ref_overflow = 1'b1;
			end
			if (b.last)
				ref_closed = 1'b1;
		end else if (ref_len == 0) begin
			query_beats++;
			if (b.last) begin
				new_row = 1'b1;
				r.status = ST_NO_REF;
				dist_due.insert(dist_due.size(), r);
			end
		end else begin
			query_beats++;
			diag = '0;
			for (int j = 0; j < ref_len; j++) begin
				d = sq_dist(b.point_x, b.point_y, ref_xs[j], ref_ys[j]);
				up = dp_row[j];
				if (new_row && j == 0)
					entry = d;
				else if (new_row)
					entry = max33(dp_row[j-1], d);
				else if (j == 0)
					entry = max33(up, d);
				else
					entry = max33(min33(min33(up, dp_row[j-1]), diag), d);
				diag = up;
				dp_row[j] = entry;
			end
			new_row = 1'b0;
			if (b.last) begin
				new_row = 1'b1;
				r.dist_squared = dp_row[ref_len-1];
				r.status = ref_overflow ? ST_TRUNC : ST_OK;
				dist_due.insert(dist_due.size(), r);
			end
		end
	endtask

	// driver: hold a beat until taken, otherwise offer the next one or idle
	always @(negedge clk) begin
		if (arst_n && !(start && !took_beat)) begin
			if (point_queue.size() != 0 &&
					((beats_sent >= CALM_FIRST && beats_sent < CALM_LAST) ||
					$urandom_range(0, 99) >= IDLE_PCT)) begin
				item_bus <= point_queue.pop_front();
				start <= 1'b1;
				beats_sent <= beats_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results first, then track the beat taken at this edge
	always @(posedge clk) begin
		dfd_out_t want;
		if (arst_n) begin
			if (strobe) begin
				results_seen++;
				if (dist_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, got dist_squared %0d status %0d",
						$time, result.dist_squared, result.status);
				end else begin
					want = dist_due.pop_front();
					if (result.dist_squared !== want.dist_squared) begin
						mismatches++;
						$display("%0t: dist_squared expected %0d got %0d", $time,
							want.dist_squared, result.dist_squared);
					end
					if (result.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d got %0d", $time,
							want.status, result.status);
					end
					if (result.done_res !== want.done_res) begin
						mismatches++;
						$display("%0t: done_res expected %0d got %0d", $time,
							want.done_res, result.done_res);
					end
					if (want.status == ST_TRUNC)
						trunc_seen++;
					if (want.status == ST_NO_REF)
						noref_seen++;
				end
			end
			if (start && !busy)
				frechet_step(item_bus);
			took_beat <= start && !busy;
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet = 0;
			else
				quiet++;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_discrete_frechet_distance_unit: FAIL");
			$finish;
		end
	end

	task automatic push_beat(logic op, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic last);
		dfd_in_t b;
		b.opcode = op;
		b.point_x = x;
		b.point_y = y;
		b.last = last;
		point_queue.insert(point_queue.size(), b);
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord(int spread);
		case (spread)
			SPREAD_FULL: return COORD_W'($urandom_range(0, 65535));
			SPREAD_NEAR: return COORD_W'($urandom_range(0, 128) - 64);
			default: begin
				case ($urandom_range(0, 3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return -16'sd1;
				endcase
			end
		endcase
	endfunction

	// n points of one curve, last mark on the final one when closed
	task automatic push_curve(logic op, int n, int spread, bit closed);
		for (int i = 0; i < n; i++)
			push_beat(op, pick_coord(spread), pick_coord(spread), closed && i == n - 1);
	endtask

	function automatic int pick_spread();
		int s;
		s = $urandom_range(0, 99);
		if (s < 50)
			return SPREAD_FULL;
		else if (s < 85)
			return SPREAD_NEAR;
		return SPREAD_EDGE;
	endfunction

	initial begin
		int sel;
		int len;
		int spread;

		// queries before any reference: ignored, then a no-reference result
		push_beat(OP_QUERY, 16'sd5, 16'sd5, 1'b0);
		push_beat(OP_QUERY, 16'sd5, 16'sd5, 1'b1);
		// single point reference at one corner, query at the far corner
		push_beat(OP_LOAD, COORD_MIN, COORD_MIN, 1'b1);
		push_beat(OP_QUERY, COORD_MAX, COORD_MAX, 1'b1);
		push_beat(OP_QUERY, COORD_MIN, COORD_MAX, 1'b0);
		push_beat(OP_QUERY, COORD_MAX, COORD_MIN, 1'b1);
		// new reference replaces the closed one
		push_beat(OP_LOAD, 16'sd0, 16'sd0, 1'b0);
		push_beat(OP_LOAD, 16'sd16, 16'sd0, 1'b0);
		push_beat(OP_LOAD, 16'sd32, 16'sd0, 1'b1);
		push_beat(OP_QUERY, 16'sd0, 16'sd1, 1'b0);
		push_beat(OP_QUERY, 16'sd32, 16'sd1, 1'b1);
		push_beat(OP_QUERY, 16'sd0, 16'sd0, 1'b0);
		push_beat(OP_QUERY, 16'sd16, 16'sd0, 1'b0);
		push_beat(OP_QUERY, 16'sd32, 16'sd0, 1'b1);
		// unfinished reference, a load that abandons a running query
		push_beat(OP_LOAD, 16'sd0, 16'sd0, 1'b0);
		push_beat(OP_QUERY, 16'sd5, 16'sd5, 1'b0);
		push_beat(OP_LOAD, 16'sd100, -16'sd100, 1'b0);
		push_beat(OP_QUERY, 16'sd1, 16'sd1, 1'b0);
		push_beat(OP_QUERY, 16'sd99, -16'sd99, 1'b1);
		push_beat(OP_LOAD, 16'sd7, 16'sd7, 1'b1);
		push_beat(OP_QUERY, 16'sd7, 16'sd7, 1'b1);
		push_beat(OP_QUERY, -16'sd1, COORD_MAX, 1'b1);

		while (point_queue.size() < ITEM_TARGET) begin
			sel = $urandom_range(0, 99);
			spread = pick_spread();
			if (sel < 60) begin
				if ($urandom_range(0, 99) < 4)
					len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
				else if ($urandom_range(0, 99) < 10)
					len = $urandom_range(9, MAX_POINTS);
				else
					len = $urandom_range(1, 8);
				push_curve(OP_LOAD, len, spread, 1'b1);
				repeat ($urandom_range(1, 4))
					push_curve(OP_QUERY, $urandom_range(1, 10), pick_spread(), 1'b1);
			end else if (sel < 75) begin
				push_curve(OP_QUERY, $urandom_range(1, 10), spread, 1'b1);
			end else if (sel < 85) begin
				// query cut short by loads, reference may stay open
				push_curve(OP_QUERY, $urandom_range(1, 6), spread, 1'b0);
				push_curve(OP_LOAD, $urandom_range(1, 4), spread, 1'($urandom_range(0, 1)));
				push_curve(OP_QUERY, $urandom_range(1, 6), spread, 1'b1);
			end else begin
				push_beat(1'($urandom_range(0, 1)), pick_coord(spread), pick_coord(spread),
					1'($urandom_range(0, 1)));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (point_queue.size() != 0 || start)
			@(posedge clk);
		while (dist_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d reference points and %0d query points", load_beats, query_beats);
		$display("checked %0d distances, %0d on truncated references, %0d without a reference",
			results_seen, trunc_seen, noref_seen);
		if (mismatches == 0)
			$display("tb_discrete_frechet_distance_unit: PASS");
		else
			$display("tb_discrete_frechet_distance_unit: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dfd_pkg.sv
rtl/dfd_cell.sv
rtl/discrete_frechet_distance_unit.sv
rtl/dfd_checker.sv
verif/tb_discrete_frechet_distance_unit.sv
